// File: src/bmw_pkg.sv
`default_nettype none
package bmw_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int VTX_W        = 10;
  localparam int VCNT_W       = 11;
  localparam int WEIGHT_W     = 30;
  localparam int SUM_W        = 40;
  localparam int RANK_W       = 4;
  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

  typedef struct packed {
    logic [VTX_W-1:0]    src;
    logic [VTX_W-1:0]    dst;
    logic [WEIGHT_W-1:0] w;
  } edge_t;

  localparam int EDGE_W = $bits(edge_t);

endpackage
`default_nettype wire

// File: src/bmw_edge_if.sv
`default_nettype none
interface bmw_edge_if import bmw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VTX_W-1:0]    source_vertex;
  logic [VTX_W-1:0]    dest_vertex;
  logic [WEIGHT_W-1:0] edge_weight;
  logic                last_edge;

  modport source (output valid, source_vertex, dest_vertex, edge_weight, last_edge,
                  input ready);
  modport sink (input valid, source_vertex, dest_vertex, edge_weight, last_edge,
                output ready);
endinterface
`default_nettype wire

// File: src/bmw_result_if.sv
`default_nettype none
interface bmw_result_if import bmw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SUM_W-1:0]  total_weight;
  logic [VCNT_W-1:0] component_count;

  modport source (output valid, total_weight, component_count, input ready);
  modport sink (input valid, total_weight, component_count, output ready);
endinterface
`default_nettype wire

// File: src/bmw_ram.sv
`default_nettype none
module bmw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [AW-1:0]       waddr,
  input  wire logic [WIDTH-1:0]    wdata,
  input  wire logic [AW-1:0]       raddr,
  output logic      [WIDTH-1:0]    rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: src/boruvka_mst_weight.sv
// Edge load: one item per cycle while loading, stored in order; items beyond MAX_EDGES are
// dropped. After the last item the forest is rebuilt over n vertices; each round then has a
// start step, a clear of the cheapest table (from the second round on), an edge pass and a
// vertex pass; a final census visits each vertex. Finds walk the parent memory, one hop per
// cycle. Loading of the next graph may proceed while the result waits. Reset (rst,
// synchronous): control cleared, vertex_count = 1024; memories not cleared.
`default_nettype none
module boruvka_mst_weight import bmw_pkg::*; #(
  parameter int MAX_EDGES = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [VCNT_W-1:0] cfg_wr_data,
  bmw_edge_if.sink               edge_in,
  bmw_result_if.source           result_out
);
  localparam int EW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW   = $clog2(MAX_EDGES + 1);
  localparam int CH_W = 1 + WEIGHT_W + EW;

  typedef enum logic [21:0] {
    S_LOAD    = 22'b1 << 0,
    S_INIT    = 22'b1 << 1,
    S_CLR     = 22'b1 << 2,
    S_RSTART  = 22'b1 << 3,
    S_E_RD    = 22'b1 << 4,
    S_E_CHK   = 22'b1 << 5,
    S_E_NEXT  = 22'b1 << 6,
    S_F_ISSUE = 22'b1 << 7,
    S_F_CHK   = 22'b1 << 8,
    S_C_RDA   = 22'b1 << 9,
    S_C_UPA   = 22'b1 << 10,
    S_C_UPB   = 22'b1 << 11,
    S_V_RD    = 22'b1 << 12,
    S_V_CHK   = 22'b1 << 13,
    S_V_EDGE  = 22'b1 << 14,
    S_V_NEXT  = 22'b1 << 15,
    S_J_RKA   = 22'b1 << 16,
    S_J_RKB   = 22'b1 << 17,
    S_J_DO    = 22'b1 << 18,
    S_CNT_RD  = 22'b1 << 19,
    S_CNT_CHK = 22'b1 << 20,
    S_DONE    = 22'b1 << 21
  } state_t;

  state_t state;

  // control and datapath registers
  logic [VCNT_W-1:0]   vertex_count;
  logic [VCNT_W-1:0]   n;
  logic [CW-1:0]       cnt;
  logic [SUM_W-1:0]    sum;
  logic [EW-1:0]       e;
  logic [VCNT_W-1:0]   vi;
  logic [VTX_W-1:0]    find_x;
  logic [VTX_W-1:0]    find_start;
  logic                second;
  logic                p2;
  logic                merged;
  logic [VTX_W-1:0]    a_root;
  logic [VTX_W-1:0]    b_root;
  logic [VTX_W-1:0]    dst;
  logic [WEIGHT_W-1:0] w;
  logic [RANK_W-1:0]   ra;
  logic [VCNT_W-1:0]   comps;
  logic                out_valid;
  logic [SUM_W-1:0]    out_tw;
  logic [VCNT_W-1:0]   out_cc;

  // memory ports
  logic                par_we;
  logic [VTX_W-1:0]    par_waddr, par_wdata, par_raddr, par_rdata;
  logic                rank_we;
  logic [VTX_W-1:0]    rank_waddr, rank_raddr;
  logic [RANK_W-1:0]   rank_wdata, rank_rdata;
  logic                ch_we;
  logic [VTX_W-1:0]    ch_waddr, ch_raddr;
  logic [CH_W-1:0]     ch_wdata, ch_rdata;
  logic                edge_we;
  logic [EW-1:0]       edge_waddr, edge_raddr;
  edge_t               edge_wdata, edge_rdata;
  logic                used_we;
  logic [EW-1:0]       used_waddr;
  logic                used_wdata, used_rdata;

  logic                accept;
  logic                room;
  logic [VCNT_W-1:0]   n_clamp;
  logic                found;
  logic                ch_valid;
  logic [WEIGHT_W-1:0] ch_w;
  logic [EW-1:0]       ch_idx;
  logic                better;
  logic                v_last;
  logic                e_last;
  logic                out_load;

  assign edge_in.ready              = (state == S_LOAD);
  assign accept                     = edge_in.valid && edge_in.ready;
  assign room                       = (cnt < CW'(MAX_EDGES));
  assign result_out.valid           = out_valid;
  assign result_out.total_weight    = out_tw;
  assign result_out.component_count = out_cc;
  // load the output register once it is free or being emptied
  assign out_load = (state == S_DONE) && (!out_valid || result_out.ready);

  always_comb begin
    if (vertex_count == '0) begin
      n_clamp = VCNT_W'(1);
    end else if (vertex_count > VCNT_W'(MAX_VERTICES)) begin
      n_clamp = VCNT_W'(MAX_VERTICES);
    end else begin
      n_clamp = vertex_count;
    end
  end

  assign found    = (par_rdata == find_x);
  assign ch_valid = ch_rdata[CH_W-1];
  assign ch_w     = ch_rdata[CH_W-2 -: WEIGHT_W];
  assign ch_idx   = ch_rdata[EW-1:0];
  assign better   = !ch_valid || (w < ch_w);
  assign v_last   = ((vi + VCNT_W'(1)) == n);
  assign e_last   = ((CW'(e) + CW'(1)) == cnt);

  // memory port steering
  always_comb begin
    par_we     = 1'b0;
    par_waddr  = vi[VTX_W-1:0];
    par_wdata  = vi[VTX_W-1:0];
    par_raddr  = find_x;
    rank_we    = 1'b0;
    rank_waddr = a_root;
    rank_wdata = '0;
    rank_raddr = a_root;
    ch_we      = 1'b0;
    ch_waddr   = vi[VTX_W-1:0];
    ch_wdata   = '0;
    ch_raddr   = vi[VTX_W-1:0];
    edge_we    = 1'b0;
    edge_waddr = cnt[EW-1:0];
    edge_wdata = '{src: edge_in.source_vertex, dst: edge_in.dest_vertex,
                   w: edge_in.edge_weight};
    edge_raddr = e;
    used_we    = 1'b0;
    used_waddr = e;
    used_wdata = 1'b1;
    unique case (state)
      S_LOAD: begin
        // store the item and uncover it
        edge_we    = accept && room;
        used_we    = accept && room;
        used_waddr = cnt[EW-1:0];
        used_wdata = 1'b0;
      end
      S_INIT: begin
        par_we     = 1'b1;
        rank_we    = 1'b1;
        rank_waddr = vi[VTX_W-1:0];
        ch_we      = 1'b1;
      end
      S_CLR: begin
        ch_we = 1'b1;
      end
      S_F_CHK: begin
        par_raddr = par_rdata;
        // compress: point the start vertex straight at its root
        if (found && (find_start != find_x)) begin
          par_we    = 1'b1;
          par_waddr = find_start;
          par_wdata = find_x;
        end
        if (found && second) begin
          used_we = p2 || (a_root == find_x);
        end
      end
      S_C_RDA: begin
        ch_raddr = a_root;
      end
      S_C_UPA: begin
        ch_raddr = b_root;
        ch_we    = better;
        ch_waddr = a_root;
        ch_wdata = {1'b1, w, e};
      end
      S_C_UPB: begin
        ch_we    = better;
        ch_waddr = b_root;
        ch_wdata = {1'b1, w, e};
      end
      S_V_CHK: begin
        edge_raddr = ch_idx;
      end
      S_J_RKA: begin
        rank_raddr = a_root;
      end
      S_J_RKB: begin
        rank_raddr = b_root;
      end
      S_J_DO: begin
        // union by rank: ra is rank of a, rank_rdata is rank of b
        par_we = 1'b1;
        if (ra < rank_rdata) begin
          par_waddr = a_root;
          par_wdata = b_root;
        end else begin
          par_waddr = b_root;
          par_wdata = a_root;
          if ((ra == rank_rdata) && (ra < RANK_MAX)) begin
            rank_we    = 1'b1;
            rank_waddr = a_root;
            rank_wdata = ra + RANK_W'(1);
          end
        end
      end
      S_CNT_RD: begin
        par_raddr = vi[VTX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      vertex_count <= VCNT_W'(MAX_VERTICES);
      cnt          <= '0;
      sum          <= '0;
      out_valid    <= 1'b0;
      merged       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        vertex_count <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (room) begin
              cnt <= cnt + CW'(1);
            end
            if (edge_in.last_edge) begin
              n     <= n_clamp;
              vi    <= '0;
              state <= S_INIT;
            end
          end
        end
        S_INIT, S_CLR: begin
          if (v_last) begin
            state <= S_RSTART;
          end else begin
            vi <= vi + VCNT_W'(1);
          end
        end
        S_RSTART: begin
          merged <= 1'b0;
          e      <= '0;
          vi     <= '0;
          if (cnt == '0) begin
            p2    <= 1'b1;
            state <= S_V_RD;
          end else begin
            p2    <= 1'b0;
            state <= S_E_RD;
          end
        end
        S_E_RD: begin
          state <= S_E_CHK;
        end
        S_E_CHK: begin
          dst <= edge_rdata.dst;
          w   <= edge_rdata.w;
          // skip covered edges and edges that leave the vertex range
          if (used_rdata || ({1'b0, edge_rdata.src} >= n) ||
              ({1'b0, edge_rdata.dst} >= n)) begin
            state <= S_E_NEXT;
          end else begin
            find_x     <= edge_rdata.src;
            find_start <= edge_rdata.src;
            second     <= 1'b0;
            state      <= S_F_ISSUE;
          end
        end
        S_E_NEXT: begin
          if (e_last) begin
            p2    <= 1'b1;
            vi    <= '0;
            state <= S_V_RD;
          end else begin
            e     <= e + EW'(1);
            state <= S_E_RD;
          end
        end
        S_F_ISSUE: begin
          state <= S_F_CHK;
        end
        S_F_CHK: begin
          if (!found) begin
            find_x <= par_rdata;
          end else if (!second) begin
            a_root     <= find_x;
            second     <= 1'b1;
            find_x     <= dst;
            find_start <= dst;
            state      <= S_F_ISSUE;
          end else begin
            b_root <= find_x;
            if (!p2) begin
              state <= (a_root == find_x) ? S_E_NEXT : S_C_RDA;
            end else if (a_root != find_x) begin
              sum    <= sum + SUM_W'(w);
              merged <= 1'b1;
              state  <= S_J_RKA;
            end else begin
              state <= S_V_NEXT;
            end
          end
        end
        S_C_RDA: begin
          state <= S_C_UPA;
        end
        S_C_UPA: begin
          state <= S_C_UPB;
        end
        S_C_UPB: begin
          state <= S_E_NEXT;
        end
        S_V_RD: begin
          state <= S_V_CHK;
        end
        S_V_CHK: begin
          if (ch_valid) begin
            e     <= ch_idx;
            state <= S_V_EDGE;
          end else begin
            state <= S_V_NEXT;
          end
        end
        S_V_EDGE: begin
          dst        <= edge_rdata.dst;
          w          <= edge_rdata.w;
          find_x     <= edge_rdata.src;
          find_start <= edge_rdata.src;
          second     <= 1'b0;
          state      <= S_F_ISSUE;
        end
        S_V_NEXT: begin
          if (v_last) begin
            vi    <= '0;
            comps <= '0;
            state <= merged ? S_CLR : S_CNT_RD;
          end else begin
            vi    <= vi + VCNT_W'(1);
            state <= S_V_RD;
          end
        end
        S_J_RKA: begin
          state <= S_J_RKB;
        end
        S_J_RKB: begin
          ra    <= rank_rdata;
          state <= S_J_DO;
        end
        S_J_DO: begin
          state <= S_V_NEXT;
        end
        S_CNT_RD: begin
          state <= S_CNT_CHK;
        end
        S_CNT_CHK: begin
          if (par_rdata == vi[VTX_W-1:0]) begin
            comps <= comps + VCNT_W'(1);
          end
          if (v_last) begin
            state <= S_DONE;
          end else begin
            vi    <= vi + VCNT_W'(1);
            state <= S_CNT_RD;
          end
        end
        S_DONE: begin
          // hold until the output register is free, then start the next graph
          if (out_load) begin
            out_tw    <= sum;
            out_cc    <= comps;
            cnt       <= '0;
            sum       <= '0;
            state     <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  bmw_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_parent (
    .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
    .raddr(par_raddr), .rdata(par_rdata)
  );

  bmw_ram #(.WIDTH(RANK_W), .DEPTH(MAX_VERTICES)) u_rank (
    .clk(clk), .we(rank_we), .waddr(rank_waddr), .wdata(rank_wdata),
    .raddr(rank_raddr), .rdata(rank_rdata)
  );

  bmw_ram #(.WIDTH(CH_W), .DEPTH(MAX_VERTICES)) u_cheap (
    .clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
    .raddr(ch_raddr), .rdata(ch_rdata)
  );

  bmw_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edges (
    .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
    .raddr(edge_raddr), .rdata(edge_rdata)
  );

  bmw_ram #(.WIDTH(1), .DEPTH(MAX_EDGES)) u_used (
    .clk(clk), .we(used_we), .waddr(used_waddr), .wdata(used_wdata),
    .raddr(e), .rdata(used_rdata)
  );

  // a result appears only from the done state
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside done state");

  // the stored edge count never passes the edge memory depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_EDGES))
    else $error("edge count overflow");

  // a union always joins two distinct roots
  a_join_distinct: assert property (@(posedge clk) disable iff (rst)
    (state == S_J_DO) |-> (a_root != b_root))
    else $error("union of a root with itself");

  // the sum only grows in the vertex pass
  a_sum_phase: assert property (@(posedge clk) disable iff (rst)
    (sum != $past(sum)) && !$past(state == S_DONE) |-> $past(p2))
    else $error("weight sum changed outside vertex pass");
endmodule
`default_nettype wire

// File: sim/boruvka_mst_weight_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module boruvka_mst_weight_checker import bmw_pkg::*; #(
  parameter int MAX_EDGES = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [VCNT_W-1:0] cfg_wr_data,
  bmw_edge_if                    edge_mon,
  bmw_result_if                  result_mon,
  output int                     mismatch_count,
  output int                     forests_pending
);

  typedef struct packed {
    logic [SUM_W-1:0]  total;
    logic [VCNT_W-1:0] comps;
  } forest_t;

  forest_t             forest_q[$];
  logic [VCNT_W-1:0]   vertex_limit;
  edge_t               graph[MAX_EDGES];
  bit                  covered[MAX_EDGES];
  int unsigned         graph_len;
  int unsigned         parent[MAX_VERTICES];
  int unsigned         tree_rank[MAX_VERTICES];
  bit                  best_valid[MAX_VERTICES];
  logic [WEIGHT_W-1:0] best_w[MAX_VERTICES];
  int unsigned         best_e[MAX_VERTICES];

  initial begin
    mismatch_count  = 0;
    forests_pending = 0;
    graph_len       = 0;
    vertex_limit    = VCNT_W'(MAX_VERTICES);
  end

  function automatic int unsigned find_root(int unsigned v);
    int unsigned r;
    int unsigned c;
    int unsigned nx;
    r = v;
    while (parent[r] != r) r = parent[r];
    c = v;
    while (c != r) begin
      nx = parent[c];
      parent[c] = r;
      c = nx;
    end
    return r;
  endfunction

  function automatic void merge_roots(int unsigned a, int unsigned b);
    if (tree_rank[a] < tree_rank[b]) begin
      parent[a] = b;
    end else if (tree_rank[a] > tree_rank[b]) begin
      parent[b] = a;
    end else begin
      parent[b] = a;
      if (tree_rank[a] < 15) tree_rank[a]++;
    end
  endfunction

  // Boruvka rounds over the stored edges; lowest edge index wins ties
  function automatic forest_t span_forest(int unsigned n);
    forest_t     res;
    bit          merged;
    int unsigned a;
    int unsigned b;
    int unsigned e;
    res = '0;
    for (int unsigned v = 0; v < MAX_VERTICES; v++) begin
      parent[v] = v;
      tree_rank[v] = 0;
    end
    merged = 1'b1;
    while (merged) begin
      merged = 1'b0;
      for (int unsigned v = 0; v < n; v++) best_valid[v] = 1'b0;
      for (int unsigned i = 0; i < graph_len; i++) begin
        if (covered[i] || graph[i].src >= n || graph[i].dst >= n) continue;
        a = find_root(graph[i].src);
        b = find_root(graph[i].dst);
        if (a == b) begin
          covered[i] = 1'b1;
          continue;
        end
        if (!best_valid[a] || graph[i].w < best_w[a]) begin
          best_valid[a] = 1'b1;
          best_w[a] = graph[i].w;
          best_e[a] = i;
        end
        if (!best_valid[b] || graph[i].w < best_w[b]) begin
          best_valid[b] = 1'b1;
          best_w[b] = graph[i].w;
          best_e[b] = i;
        end
      end
      for (int unsigned v = 0; v < n; v++) begin
        if (!best_valid[v]) continue;
        e = best_e[v];
        a = find_root(graph[e].src);
        b = find_root(graph[e].dst);
        if (a != b) begin
          res.total = res.total + SUM_W'(graph[e].w);
          merge_roots(a, b);
          merged = 1'b1;
        end
        covered[e] = 1'b1;
      end
    end
    for (int unsigned v = 0; v < n; v++)
      if (find_root(v) == v) res.comps++;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    forest_t     want;
    int unsigned n;
    if (rst) begin
      vertex_limit = VCNT_W'(MAX_VERTICES);
      graph_len = 0;
    end else begin
      if (cfg_wr_en) vertex_limit = cfg_wr_data;
      if (edge_mon.valid && edge_mon.ready) begin
        // drop edges once the list is full; a dropped last still starts the run
        if (graph_len < MAX_EDGES) begin
          graph[graph_len] = '{src: edge_mon.source_vertex, dst: edge_mon.dest_vertex,
                               w: edge_mon.edge_weight};
          covered[graph_len] = 1'b0;
          graph_len++;
        end
        if (edge_mon.last_edge) begin
          n = vertex_limit;
          if (n < 1) n = 1;
          if (n > MAX_VERTICES) n = MAX_VERTICES;
          forest_q.insert(forest_q.size(), span_forest(n));
          graph_len = 0;
        end
      end
      if (result_mon.valid && result_mon.ready) begin
        if (forest_q.size() == 0) begin
          report_mismatch("unexpected result, total_weight", result_mon.total_weight, 0);
        end else begin
          want = forest_q.pop_front();
          if (result_mon.total_weight !== want.total)
            report_mismatch("total_weight", result_mon.total_weight, want.total);
          if (result_mon.component_count !== want.comps)
            report_mismatch("component_count", result_mon.component_count, want.comps);
        end
      end
    end
    forests_pending = forest_q.size();
  end

endmodule
`default_nettype wire

// File: sim/boruvka_mst_weight_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module boruvka_mst_weight_tb;
  import bmw_pkg::*;

  // a short edge list, so that overflowing it stays cheap
  localparam int MAX_EDGES   = 64;
  // quiet cycles allowed before the watchdog ends the run
  localparam int STALL_LIMIT = 500000;
  // idle gap before a register write, covering any tail of the engine
  localparam int SETTLE      = 40;
  localparam int HOLD_LEN    = 400;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_wr_en;
  logic [VCNT_W-1:0] cfg_wr_data;
  int                mismatch_count;
  int                forests_pending;
  int                tx_idle_pct;
  int                rx_stall_pct;
  logic              hold_req;
  int                hold_left;
  int                quiet_cycles;
  int                items_sent;

  bmw_edge_if   edge_if ();
  bmw_result_if result_if ();

  boruvka_mst_weight #(.MAX_EDGES(MAX_EDGES)) u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .edge_in    (edge_if),
    .result_out (result_if)
  );

  boruvka_mst_weight_checker #(.MAX_EDGES(MAX_EDGES)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .edge_mon       (edge_if),
    .result_mon     (result_if),
    .mismatch_count (mismatch_count),
    .forests_pending(forests_pending)
  );

  always #10 clk = ~clk;

  // Result side: random stalls, plus a long hold-off on request so that the
  // block backs up and stalls its edge input.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_if.ready <= 1'b0;
    end else if (hold_req) begin
      hold_left <= HOLD_LEN;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((edge_if.valid && edge_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Offer one edge item, idling first at random; hold valid high afterwards
  // so back-to-back items need no gap.
  task automatic push_edge(input logic [VTX_W-1:0] s, input logic [VTX_W-1:0] d,
                           input logic [WEIGHT_W-1:0] w, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      edge_if.valid <= 1'b0;
      @(posedge clk);
    end
    edge_if.valid         <= 1'b1;
    edge_if.source_vertex <= s;
    edge_if.dest_vertex   <= d;
    edge_if.edge_weight   <= w;
    edge_if.last_edge     <= last;
    @(posedge clk);
    while (!edge_if.ready) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and wait until every expected forest has come back, then let
  // the engine settle.
  task automatic drain_results();
    edge_if.valid <= 1'b0;
    do @(negedge clk); while (forests_pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_vertex_count(input logic [VCNT_W-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // One random graph on n vertices: mostly in-range endpoints, a few out of
  // range and a few self loops; weights narrow (ties), legal, or full width.
  task automatic push_random_graph(input int unsigned n, input int unsigned edges);
    logic [VTX_W-1:0]    s;
    logic [VTX_W-1:0]    d;
    logic [WEIGHT_W-1:0] w;
    int unsigned         hi;
    hi = (n > MAX_VERTICES) ? MAX_VERTICES - 1 : ((n == 0) ? 0 : n - 1);
    for (int unsigned i = 0; i < edges; i++) begin
      s = VTX_W'(($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(hi));
      d = VTX_W'(($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(hi));
      if ($urandom_range(19) == 0) d = s;
      case ($urandom_range(2))
        0: w = WEIGHT_W'($urandom_range(7));
        1: w = WEIGHT_W'($urandom_range(999999999));
        default: w = WEIGHT_W'($urandom());
      endcase
      push_edge(s, d, w, i == edges - 1);
    end
  endtask

  initial begin
    int unsigned n;
    rst             = 1'b1;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    edge_if.valid   = 1'b0;
    edge_if.source_vertex = '0;
    edge_if.dest_vertex   = '0;
    edge_if.edge_weight   = '0;
    edge_if.last_edge     = 1'b0;
    result_if.ready = 1'b0;
    hold_req        = 1'b0;
    hold_left       = 0;
    quiet_cycles    = 0;
    items_sent      = 0;
    tx_idle_pct     = 0;
    rx_stall_pct    = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset vertex count, extreme endpoints and weights, self loop
    push_edge(10'd1023, 10'd0, '1, 1'b0);
    push_edge(10'd0, 10'd1023, '0, 1'b0);
    push_edge(10'd5, 10'd5, 30'd3, 1'b0);
    push_edge(10'd1, 10'd2, 30'd999999999, 1'b1);
    push_edge(10'd7, 10'd7, 30'd1000000000, 1'b1);

    // zero vertices taken as one; every edge touching vertex 1 is ignored
    set_vertex_count('0);
    push_edge(10'd0, 10'd0, 30'd5, 1'b0);
    push_edge(10'd0, 10'd1, 30'd6, 1'b1);
    set_vertex_count(11'd1);
    push_edge(10'd0, 10'd0, 30'd9, 1'b1);

    // equal weights around a triangle plus a disconnected pair
    set_vertex_count(11'd5);
    push_edge(10'd0, 10'd1, 30'd4, 1'b0);
    push_edge(10'd1, 10'd2, 30'd4, 1'b0);
    push_edge(10'd0, 10'd2, 30'd4, 1'b0);
    push_edge(10'd3, 10'd4, 30'd2, 1'b0);
    push_edge(10'd4, 10'd9, 30'd1, 1'b1);

    // above the maximum: clamped to 1024
    set_vertex_count(11'h7FF);
    push_edge(10'd1023, 10'd512, 30'd77, 1'b0);
    push_edge(10'd0, 10'd1023, 30'h2AAAAAAA, 1'b1);

    // overflow the edge list; the last item is dropped yet starts the run
    set_vertex_count(11'd8);
    for (int i = 0; i < MAX_EDGES + 4; i++)
      push_edge(10'($urandom_range(7)), 10'($urandom_range(7)), 30'($urandom()),
                i == MAX_EDGES + 3);

    // Pressure: hold off results while graphs keep coming
    set_vertex_count(11'd12);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    for (int g = 0; g < 6; g++) push_random_graph(12, $urandom_range(1, 10));
    drain_results();

    items_sent = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 87; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 87; end
        default: begin tx_idle_pct = 16; rx_stall_pct = 16; end
      endcase
      // one full-size graph per phase, kept sparse
      set_vertex_count(11'd1024);
      push_random_graph(1024, $urandom_range(4, 24));
      while (items_sent < (phase + 1) * 184) begin
        n = ($urandom_range(3) == 0) ? $urandom_range(33, 200) : $urandom_range(1, 32);
        set_vertex_count(VCNT_W'(n));
        for (int g = 0; g < 4; g++) push_random_graph(n, $urandom_range(1, 16));
      end
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
